@@ rtl/core/awp_pkg.sv @@
// ----------------------------------------------------------------------------
// awp_pkg
// Shared types and constants for the attention-weighted pooling block.
// ----------------------------------------------------------------------------
package awp_pkg;

    localparam int MAX_MAPS_DEF   = 8;
    localparam int MAX_PIXELS_DEF = 1024;

    localparam int PIX_W  = 10;
    localparam int CHAN_W = 10;
    localparam int MAP_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    localparam int PC_W    = 11;
    localparam int MC_W    = 4;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT   = 1'b1;

    localparam logic [PC_W-1:0] PC_RESET = 11'd1024;
    localparam logic [MC_W-1:0] MC_RESET = 4'd8;

    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [MAP_W-1:0]        map_index;
        logic [PIX_W-1:0]        pixel_index;
        logic [CHAN_W-1:0]       channel_index;
        logic signed [VAL_W-1:0] weight_value;
        logic signed [VAL_W-1:0] feature_value;
    } t_in_word;

    typedef struct packed {
        logic [MAP_W-1:0]        out_map;
        logic [CHAN_W-1:0]       out_channel;
        logic signed [ACC_W-1:0] pooled_value;
        logic                    last;
    } t_out_word;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic mul_en;
        logic acc_en;
        logic acc_clr;
        logic drn_ld;
        logic drn_sh;
    } t_cell_ctl;

endpackage

@@ rtl/core/attention_weighted_pooling.sv @@
// ----------------------------------------------------------------------------
// attention_weighted_pooling
// Attention-weighted spatial pooling over a chain of per-map cells.
//
//   port group   dir  handshake          word
//   input        in   i_valid/o_ready    i_word  (t_in_word)
//   result       out  o_valid/i_ready    o_word  (t_out_word)
//   config       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// One word per cycle in while o_ready is high; a sample is read, multiplied
// and added into the sums. A channel's last pixel then loads all sums into the
// drain chain, which gives one result per cycle while i_ready is high,
// map_count per channel. A channel end that finds the drain busy, other than
// with its last word being taken, holds the pipeline and drops o_ready.
// Reset clears sums, control and config; weight memories are not cleared.
// ----------------------------------------------------------------------------
module attention_weighted_pooling #(
    parameter int MAX_MAPS   = awp_pkg::MAX_MAPS_DEF,
    parameter int MAX_PIXELS = awp_pkg::MAX_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  awp_pkg::t_in_word               i_word,
    output logic                            o_valid,
    input  logic                            i_ready,
    output awp_pkg::t_out_word              o_word,
    input  logic                            i_cfg_we,
    input  logic [awp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [awp_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int NP_W = $clog2(MAX_PIXELS + 1);
    localparam int NM_W = $clog2(MAX_MAPS + 1);

    logic [awp_pkg::PC_W-1:0] r_pc;
    logic [awp_pkg::MC_W-1:0] r_mc;

    logic [NP_W-1:0] np;
    logic [NM_W-1:0] nm;
    logic [31:0]     pix_w;
    logic [31:0]     map_w;
    logic [31:0]     np_w;
    logic [31:0]     nm_w;
    logic [AW-1:0]   addr;

    logic en;
    logic acc_in;
    logic is_smp;
    logic smp_ok;
    logic ld_ok;

    logic                              r1_v;
    logic                              r1_clr;
    logic                              r1_lst;
    logic [awp_pkg::CHAN_W-1:0]        r1_chan;
    logic signed [awp_pkg::VAL_W-1:0]  r1_feat;
    logic                              r2_v;
    logic                              r2_clr;
    logic                              r2_lst;
    logic [awp_pkg::CHAN_W-1:0]        r2_chan;
    logic                              r3_v;
    logic [awp_pkg::CHAN_W-1:0]        r3_chan;

    logic [NM_W-1:0]            r_cnt;
    logic [NM_W-1:0]            r_idx;
    logic [awp_pkg::CHAN_W-1:0] r_chan;
    logic [31:0]                idx_w;

    awp_pkg::t_cell_ctl ctl;
    logic [MAX_MAPS-1:0] wsel;
    logic [MAX_MAPS-1:0] use_m;
    logic signed [awp_pkg::ACC_W-1:0] slot [MAX_MAPS+1];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= awp_pkg::PC_RESET;
            r_mc <= awp_pkg::MC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                awp_pkg::CFG_PIXEL_COUNT: r_pc <= i_cfg_data[awp_pkg::PC_W-1:0];
                awp_pkg::CFG_MAP_COUNT:   r_mc <= i_cfg_data[awp_pkg::MC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_pc == '0) begin
            np = NP_W'(1);
        end else if (32'(r_pc) > 32'(MAX_PIXELS)) begin
            np = NP_W'(MAX_PIXELS);
        end else begin
            np = NP_W'(r_pc);
        end
        if (r_mc == '0) begin
            nm = NM_W'(1);
        end else if (32'(r_mc) > 32'(MAX_MAPS)) begin
            nm = NM_W'(MAX_MAPS);
        end else begin
            nm = NM_W'(r_mc);
        end
    end

    assign pix_w = 32'(i_word.pixel_index);
    assign map_w = 32'(i_word.map_index);
    assign np_w  = 32'(np);
    assign nm_w  = 32'(nm);
    assign addr  = pix_w[AW-1:0];

    // drain may reload on the edge that takes its last word
    assign en      = !(r3_v && (r_cnt != '0) && !((r_cnt == NM_W'(1)) && i_ready));
    assign o_ready = en;
    assign acc_in  = i_valid && en;
    assign is_smp  = (i_word.req_type == awp_pkg::REQ_SAMPLE);
    assign smp_ok  = is_smp && (pix_w < np_w);
    assign ld_ok   = !is_smp && (pix_w < 32'(MAX_PIXELS));

    // sample pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= acc_in && smp_ok;
            r2_v <= r1_v;
            r3_v <= r2_v && r2_lst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_clr  <= (pix_w == 32'd0);
            r1_lst  <= ((pix_w + 32'd1) == np_w);
            r1_chan <= i_word.channel_index;
            r1_feat <= i_word.feature_value;
            r2_clr  <= r1_clr;
            r2_lst  <= r1_lst;
            r2_chan <= r1_chan;
            r3_chan <= r2_chan;
        end
    end

    always_comb begin
        ctl.wr_en   = acc_in && ld_ok;
        ctl.rd_en   = acc_in && smp_ok;
        ctl.mul_en  = en && r1_v;
        ctl.acc_en  = en && r2_v;
        ctl.acc_clr = r2_clr;
        ctl.drn_ld  = en && r3_v;
        ctl.drn_sh  = o_valid && i_ready;
    end

    // drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (ctl.drn_ld) begin
            r_cnt <= nm;
            r_idx <= '0;
        end else if (ctl.drn_sh) begin
            r_cnt <= r_cnt - NM_W'(1);
            r_idx <= r_idx + NM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.drn_ld) begin
            r_chan <= r3_chan;
        end
    end

    assign slot[MAX_MAPS] = '0;

    for (genvar m = 0; m < MAX_MAPS; m++) begin : g_cell
        assign wsel[m]  = (map_w == 32'(m));
        assign use_m[m] = (nm_w > 32'(m));

        awp_cell #(
            .MAX_PIXELS (MAX_PIXELS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wsel  (wsel[m]),
            .i_use   (use_m[m]),
            .i_addr  (addr),
            .i_wdata (i_word.weight_value),
            .i_feat  (r1_feat),
            .i_next  (slot[m+1]),
            .o_slot  (slot[m])
        );
    end

    assign idx_w   = 32'(r_idx);
    assign o_valid = (r_cnt != '0);

    always_comb begin
        o_word.out_map      = idx_w[awp_pkg::MAP_W-1:0];
        o_word.out_channel  = r_chan;
        o_word.pooled_value = slot[0];
        o_word.last         = (r_cnt == NM_W'(1));
    end

endmodule

@@ rtl/core/awp_cell.sv @@
// ----------------------------------------------------------------------------
// awp_cell
// One map lane: weight memory, multiply-accumulate, and one slot of the
// result drain chain that shifts toward cell 0.
// ----------------------------------------------------------------------------
module awp_cell #(
    parameter int  MAX_PIXELS = awp_pkg::MAX_PIXELS_DEF,
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  awp_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_wsel,
    input  logic                              i_use,
    input  logic [AW-1:0]                     i_addr,
    input  logic signed [awp_pkg::VAL_W-1:0]  i_wdata,
    input  logic signed [awp_pkg::VAL_W-1:0]  i_feat,
    input  logic signed [awp_pkg::ACC_W-1:0]  i_next,
    output logic signed [awp_pkg::ACC_W-1:0]  o_slot
);

    logic signed [awp_pkg::VAL_W-1:0]  r_mem [MAX_PIXELS];
    logic signed [awp_pkg::VAL_W-1:0]  r_w;
    logic signed [awp_pkg::PROD_W-1:0] r_prod;
    logic signed [awp_pkg::ACC_W-1:0]  r_acc;
    logic signed [awp_pkg::ACC_W-1:0]  n_acc;
    logic signed [awp_pkg::ACC_W-1:0]  r_slot;
    logic signed [awp_pkg::ACC_W-1:0]  prod_x;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_wsel) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_w <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= awp_pkg::PROD_W'(r_w) * awp_pkg::PROD_W'(i_feat);
        end
    end

    assign prod_x = awp_pkg::ACC_W'(r_prod);

    always_comb begin
        if (i_ctl.acc_clr) begin
            n_acc = i_use ? prod_x : '0;
        end else if (i_use) begin
            n_acc = r_acc + prod_x;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.drn_ld) begin
            r_slot <= r_acc;
        end else if (i_ctl.drn_sh) begin
            r_slot <= i_next;
        end
    end

    assign o_slot = r_slot;

endmodule

@@ bench/tb_attention_weighted_pooling.sv @@
// ----------------------------------------------------------------------------
// tb_attention_weighted_pooling
// Self-checking bench for attention-weighted pooling. Weights are loaded, then
// channels of samples stream in under a series of pixel and map counts, some
// of them out of range. Every result word is checked against a bench-side
// model of the per-map weighted sums. Both handshakes stall in random bursts.
// ----------------------------------------------------------------------------
module tb_attention_weighted_pooling;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 370;
    localparam int NMAP          = awp_pkg::MAX_MAPS_DEF;
    localparam int NPIX          = awp_pkg::MAX_PIXELS_DEF;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_valid    = 1'b0;
    logic                          o_ready;
    awp_pkg::t_in_word             i_word     = '0;
    logic                          o_valid;
    logic                          i_ready    = 1'b0;
    awp_pkg::t_out_word            o_word;
    logic                          i_cfg_we   = 1'b0;
    logic [awp_pkg::CFG_IDX_W-1:0] i_cfg_idx  = awp_pkg::CFG_PIXEL_COUNT;
    logic [awp_pkg::CFG_W-1:0]     i_cfg_data = '0;

    attention_weighted_pooling dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // bench copy of the block state
    logic [awp_pkg::PC_W-1:0]         pix_cnt = awp_pkg::PC_RESET;
    logic [awp_pkg::MC_W-1:0]         map_cnt = awp_pkg::MC_RESET;
    logic signed [awp_pkg::VAL_W-1:0] attn_wt [NMAP][NPIX];
    logic signed [awp_pkg::ACC_W-1:0] map_acc [NMAP] = '{default: '0};

    // generator side: weights already queued for load
    bit                      wt_ready [NMAP][NPIX];

    awp_pkg::t_in_word       in_words[$];
    awp_pkg::t_out_word      pooled_sums[$];

    int unsigned n_err    = 0;
    int unsigned n_queued = 0;
    int unsigned cycles   = 0;
    int unsigned tx_gap   = 0;
    int unsigned rx_gap   = 0;
    bit          calm     = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pixels_in_use();
        if (pix_cnt == 0) return 1;
        if (pix_cnt > NPIX) return NPIX;
        return pix_cnt;
    endfunction

    function automatic int unsigned maps_in_use();
        if (map_cnt == 0) return 1;
        if (map_cnt > NMAP) return NMAP;
        return map_cnt;
    endfunction

    function automatic void pool_accumulate(awp_pkg::t_in_word w);
        int unsigned                       np;
        int unsigned                       nm;
        logic signed [awp_pkg::PROD_W-1:0] prod;
        awp_pkg::t_out_word                r;
        np = pixels_in_use();
        nm = maps_in_use();
        if (w.req_type == awp_pkg::REQ_WEIGHT) begin
            attn_wt[w.map_index][w.pixel_index] = w.weight_value;
            return;
        end
        if (w.pixel_index >= np) return;
        if (w.pixel_index == 0) begin
            foreach (map_acc[m]) map_acc[m] = '0;
        end
        for (int m = 0; m < nm; m++) begin
            prod = $signed(w.feature_value) * attn_wt[m][w.pixel_index];
            map_acc[m] = map_acc[m] + prod;
        end
        if (w.pixel_index != np - 1) return;
        for (int m = 0; m < nm; m++) begin
            r.out_map      = awp_pkg::MAP_W'(m);
            r.out_channel  = w.channel_index;
            r.pooled_value = map_acc[m];
            r.last         = (m == nm - 1);
            pooled_sums.push_back(r);
        end
    endfunction

    function automatic logic [awp_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return awp_pkg::VAL_W'($urandom);
        endcase
    endfunction

    function automatic void queue_load(int unsigned mi, int unsigned px);
        awp_pkg::t_in_word w;
        w.req_type      = awp_pkg::REQ_WEIGHT;
        w.map_index     = awp_pkg::MAP_W'(mi);
        w.pixel_index   = awp_pkg::PIX_W'(px);
        w.channel_index = awp_pkg::CHAN_W'($urandom);
        w.weight_value  = rand_val();
        w.feature_value = rand_val();
        in_words.push_back(w);
        wt_ready[mi][px] = 1'b1;
        n_queued++;
    endfunction

    // loads any weight the sample would read that was never written
    function automatic void queue_sample(int unsigned px,
                                         logic [awp_pkg::CHAN_W-1:0] ch);
        awp_pkg::t_in_word w;
        if (px < pixels_in_use()) begin
            for (int m = 0; m < maps_in_use(); m++) begin
                if (!wt_ready[m][px]) queue_load(m, px);
            end
            n_queued++;
        end
        w.req_type      = awp_pkg::REQ_SAMPLE;
        w.map_index     = awp_pkg::MAP_W'($urandom);
        w.pixel_index   = awp_pkg::PIX_W'(px);
        w.channel_index = ch;
        w.weight_value  = rand_val();
        w.feature_value = rand_val();
        in_words.push_back(w);
    endfunction

    // large maps are walked sparsely: pixel 0 unless from_zero is clear, a few inner pixels, the last
    function automatic void queue_channel(bit from_zero);
        int unsigned                np;
        logic [awp_pkg::CHAN_W-1:0] ch;
        np = pixels_in_use();
        ch = awp_pkg::CHAN_W'($urandom);
        for (int p = 0; p < np; p++) begin
            if (p == 0 && !from_zero && np > 1) continue;
            if (np > 16 && p != 0 && p != np - 1 && $urandom_range(0, 199) != 0) continue;
            if ($urandom_range(0, 9) == 0) begin
                if (np < NPIX && $urandom_range(0, 1) == 1)
                    queue_sample($urandom_range(np, NPIX - 1),
                                 awp_pkg::CHAN_W'($urandom));
                else
                    queue_load($urandom_range(0, NMAP - 1), $urandom_range(0, NPIX - 1));
            end
            queue_sample(p, ($urandom_range(0, 7) == 0) ? awp_pkg::CHAN_W'($urandom) : ch);
        end
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (in_words.size() != 0 || i_valid || pooled_sums.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [awp_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= awp_pkg::CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == awp_pkg::CFG_PIXEL_COUNT) pix_cnt = awp_pkg::PC_W'(val);
        else map_cnt = awp_pkg::MC_W'(val);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) pool_accumulate(i_word);
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (in_words.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    tx_gap = $urandom_range(0, 17);
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_word  <= in_words.pop_front();
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin : rx_side
        awp_pkg::t_out_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pooled_sums.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected word: map %0d chan %0d sum %0d last %0b",
                                 o_word.out_map, o_word.out_channel,
                                 o_word.pooled_value, o_word.last);
                end else begin
                    want = pooled_sums.pop_front();
                    if (o_word !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("exp/got map %0d/%0d ch %0d/%0d sum %0d/%0d last %0b/%0b",
                                     want.out_map, o_word.out_map,
                                     want.out_channel, o_word.out_channel,
                                     want.pooled_value, o_word.pooled_value,
                                     want.last, o_word.last);
                    end
                end
            end
            if (rx_gap != 0) begin
                rx_gap--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_attention_weighted_pooling: done, errors");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned pc;
        int unsigned mc;
        phase = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset counts: last pixel only, sums build on the reset zeros
        for (int m = 0; m < NMAP; m++) begin
            queue_load(m, NPIX - 1);
            in_words[$].weight_value = (m % 2 == 1) ? 16'h7fff : 16'h8000;
        end
        queue_sample(NPIX - 1, 10'h3ff);
        in_words[$].feature_value = 16'h8000;
        queue_sample(NPIX - 1, 10'h000);
        in_words[$].feature_value = 16'h7fff;

        // zero counts act as one pixel, one map
        wait_drained();
        write_reg(awp_pkg::CFG_PIXEL_COUNT, 0);
        write_reg(awp_pkg::CFG_MAP_COUNT, 0);
        @(negedge i_clk);
        queue_load(0, 0);
        in_words[$].weight_value = 16'h7fff;
        queue_sample(0, 10'h155);
        in_words[$].feature_value = 16'h8000;
        queue_sample(1, 10'h2aa);
        queue_sample(0, 10'h0f0);
        in_words[$].feature_value = 16'hffff;

        // oversized counts clamp to the maximum
        wait_drained();
        write_reg(awp_pkg::CFG_PIXEL_COUNT, 2047);
        write_reg(awp_pkg::CFG_MAP_COUNT, 15);
        @(negedge i_clk);
        queue_sample(NPIX - 1, 10'h200);
        in_words[$].feature_value = 16'h7fff;

        while (n_queued < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(0, 15))
                0:       pc = 0;
                1:       pc = NPIX;
                2:       pc = $urandom_range(NPIX + 1, 2047);
                3:       pc = $urandom_range(13, 64);
                default: pc = $urandom_range(1, 12);
            endcase
            mc = $urandom_range(0, 15);
            if (phase == 0) begin
                pc = 1;
                mc = NMAP;
            end else if (phase == 1) begin
                pc = NPIX;
                mc = 1;
            end
            write_reg(awp_pkg::CFG_PIXEL_COUNT, pc);
            write_reg(awp_pkg::CFG_MAP_COUNT, mc);
            if (n_queued + 70 > RANDOM_ITEMS) calm = 1'b1;
            @(negedge i_clk);
            repeat ($urandom_range(1, 4)) begin
                if (n_queued < RANDOM_ITEMS) queue_channel($urandom_range(0, 5) != 0);
            end
            phase++;
        end

        wait_drained();
        if (n_err == 0) begin
            $display("tb_attention_weighted_pooling: done, clean");
        end else begin
            $display("tb_attention_weighted_pooling: done, errors");
        end
        $finish;
    end

endmodule
